/* src/stopword_language_detector_core_defines.svh */
// Assertion macros shared by the stopword language detector RTL.
`ifndef STOPWORD_LANGUAGE_DETECTOR_CORE_DEFINES_SVH
`define STOPWORD_LANGUAGE_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define SLDET_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define SLDET_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define SLDET_ASSERT(lbl, clk, rst_n, prop, msg)

`define SLDET_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* src/sldet_pkg.sv */
// Types, constants, word tables and helper functions of the stopword language detector.
package sldet_pkg;

    // Token geometry
    localparam int TOKEN_BYTES = 4;
    localparam int TOKEN_BITS  = TOKEN_BYTES * 8;
    localparam int LEN_W       = 3;
    localparam int IDX_W       = $clog2(TOKEN_BYTES);
    localparam logic [LEN_W-1:0] LONG_MARK = LEN_W'(TOKEN_BYTES + 1);

    // Defaults for top-level parameters
    localparam int SCORE_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int HIT_W           = 16;

    // Language codes
    localparam logic [1:0] LANG_SPANISH = 2'd0;
    localparam logic [1:0] LANG_ENGLISH = 2'd1;
    localparam logic [1:0] LANG_GERMAN  = 2'd2;

    // Positions in the per-token hit vector
    localparam int HIT_ES = 0;
    localparam int HIT_EN = 1;
    localparam int HIT_DE = 2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]       language;
        logic [HIT_W-1:0] spanish_hits;
        logic [HIT_W-1:0] english_hits;
        logic [HIT_W-1:0] german_hits;
    } result_item_t;

    // Closed token, first character in the most significant byte
    typedef struct packed {
        logic [TOKEN_BITS-1:0] text;
        logic [LEN_W-1:0]      len;
        logic                  last;
    } token_t;

    // Stop-word tables, words left-justified and zero padded
    localparam int ES_WORDS = 9;
    localparam int EN_WORDS = 8;
    localparam int DE_WORDS = 8;

    localparam logic [LEN_W-1:0] ES_LEN [ES_WORDS] =
        '{3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd1, 3'd3, 3'd2};
    localparam logic [TOKEN_BITS-1:0] ES_TEXT [ES_WORDS] =
        '{{"el", 16'h0}, {"la", 16'h0}, {"los", 8'h0}, {"las", 8'h0},
          {"un", 16'h0}, {"una", 8'h0}, {"y", 24'h0}, {"que", 8'h0},
          {"es", 16'h0}};

    localparam logic [LEN_W-1:0] EN_LEN [EN_WORDS] =
        '{3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
    localparam logic [TOKEN_BITS-1:0] EN_TEXT [EN_WORDS] =
        '{{"the", 8'h0}, {"and", 8'h0}, {"for", 8'h0}, "with",
          "from", "that", "have", "this"};

    localparam logic [LEN_W-1:0] DE_LEN [DE_WORDS] =
        '{3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3};
    localparam logic [TOKEN_BITS-1:0] DE_TEXT [DE_WORDS] =
        '{{"der", 8'h0}, {"die", 8'h0}, {"das", 8'h0}, {"und", 8'h0},
          {"von", 8'h0}, {"mit", 8'h0}, {"auf", 8'h0}, {"bei", 8'h0}};

    // Token separators, NUL included
    function automatic logic is_delim(input logic [7:0] c);
        return c inside {8'h20, 8'h2E, 8'h2C, 8'h3B, 8'h3A,
                         8'h21, 8'h3F, 8'h0A, 8'h09, 8'h00};
    endfunction

    // ASCII lowercase, other bytes unchanged
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? c + 8'h20 : c;
    endfunction

    // Compare one token against all three tables in parallel
    function automatic logic [2:0] token_hits(input logic [TOKEN_BITS-1:0] text,
                                              input logic [LEN_W-1:0]      len);
        logic [TOKEN_BITS-1:0] mask;
        logic [TOKEN_BITS-1:0] masked;
        logic [2:0]            hits;
        logic                  usable;
        mask   = ~({TOKEN_BITS{1'b1}} >> {len, 3'b000});
        masked = text & mask;
        usable = (len != '0) && (len <= LEN_W'(TOKEN_BYTES));
        hits   = '0;
        for (int i = 0; i < ES_WORDS; i++) begin
            if (usable && len == ES_LEN[i] && masked == ES_TEXT[i]) hits[HIT_ES] = 1'b1;
        end
        for (int i = 0; i < EN_WORDS; i++) begin
            if (usable && len == EN_LEN[i] && masked == EN_TEXT[i]) hits[HIT_EN] = 1'b1;
        end
        for (int i = 0; i < DE_WORDS; i++) begin
            if (usable && len == DE_LEN[i] && masked == DE_TEXT[i]) hits[HIT_DE] = 1'b1;
        end
        return hits;
    endfunction

endpackage

/* src/sldet_queue.sv */
// Small token queue between the tokenizer and the scoring stage.
module sldet_queue
    import sldet_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  token_t push_item,
    output logic   pop_valid,
    input  logic   pop_ready,
    output token_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    // Flags and handshakes
    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/sldet_front.sv */
// Tokenizer: takes text bytes, builds the open token and pushes closed tokens.
module sldet_front
    import sldet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    output logic       tok_valid,
    input  logic       tok_ready,
    output token_t     tok_item
);

    logic [7:0]            chars_reg [TOKEN_BYTES];
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  accept;
    logic                  delim;
    logic                  closing;
    logic [7:0]            lower;
    logic [TOKEN_BITS-1:0] cur_text;
    logic [TOKEN_BITS-1:0] app_text;
    logic [LEN_W-1:0]      app_len;

    // Hold the input while the queue is full
    assign byte_stall = !tok_ready;
    assign accept     = byte_valid && tok_ready;
    assign delim      = is_delim(byte_item.text_byte);
    assign lower      = to_lower(byte_item.text_byte);
    assign closing    = delim || byte_item.final_byte;

    // Open token as it stands, and with this byte appended
    always_comb
    begin
        for (int k = 0; k < TOKEN_BYTES; k++)
        begin
            cur_text[(TOKEN_BYTES-1-k)*8 +: 8] = chars_reg[k];
            app_text[(TOKEN_BYTES-1-k)*8 +: 8] =
                (len_reg == LEN_W'(k)) ? lower : chars_reg[k];
        end
        app_len = (len_reg < LONG_MARK) ? len_reg + 1'b1 : len_reg;
    end

    // Push the closed token on a separator or on the last byte
    always_comb
    begin
        tok_valid     = accept && closing;
        tok_item.text = delim ? cur_text : app_text;
        tok_item.len  = delim ? len_reg : app_len;
        tok_item.last = byte_item.final_byte;
    end

    // Advance or clear the token length
    always_comb
    begin
        len_next = len_reg;
        if (accept)
        begin
            len_next = closing ? '0 : app_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // Store token characters while there is room
    always_ff @(posedge clk)
    begin
        if (accept && !delim && len_reg < LEN_W'(TOKEN_BYTES))
        begin
            chars_reg[len_reg[IDX_W-1:0]] <= lower;
        end
    end

endmodule

/* src/sldet_back.sv */
// Scoring stage: matches tokens, counts hits and produces the result item.
module sldet_back
    import sldet_pkg::*;
#(
    parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         tok_valid,
    output logic         tok_ready,
    input  token_t       tok_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    localparam logic [SCORE_WIDTH-1:0] SCORE_MAX = {SCORE_WIDTH{1'b1}};

    logic [SCORE_WIDTH-1:0] es_reg, es_next, en_reg, en_next, de_reg, de_next;
    logic [SCORE_WIDTH-1:0] es_bump, en_bump, de_bump;
    logic                   out_valid_reg, out_valid_next;
    result_item_t           out_reg, out_next;
    logic                   out_free;
    logic                   pop;
    logic [2:0]             hits;
    logic [1:0]             lang;
    logic [SCORE_WIDTH+HIT_W-1:0] es_ext, en_ext, de_ext;

    // Take a last token only when the output register can load
    assign out_free  = !out_valid_reg || !result_stall;
    assign tok_ready = !tok_item.last || out_free;
    assign pop       = tok_valid && tok_ready;

    // Match and bump saturating counters
    always_comb
    begin
        hits    = token_hits(tok_item.text, tok_item.len);
        es_bump = es_reg + SCORE_WIDTH'(hits[HIT_ES] && es_reg != SCORE_MAX);
        en_bump = en_reg + SCORE_WIDTH'(hits[HIT_EN] && en_reg != SCORE_MAX);
        de_bump = de_reg + SCORE_WIDTH'(hits[HIT_DE] && de_reg != SCORE_MAX);
    end

    // Pick the winner, ties to Spanish then English
    always_comb
    begin
        if (es_bump >= en_bump && es_bump >= de_bump)
        begin
            lang = LANG_SPANISH;
        end
        else if (en_bump >= de_bump)
        begin
            lang = LANG_ENGLISH;
        end
        else
        begin
            lang = LANG_GERMAN;
        end
        es_ext = {{HIT_W{1'b0}}, es_bump};
        en_ext = {{HIT_W{1'b0}}, en_bump};
        de_ext = {{HIT_W{1'b0}}, de_bump};
    end

    // Update counters, load or drop the result
    always_comb
    begin
        es_next        = es_reg;
        en_next        = en_reg;
        de_next        = de_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (pop)
        begin
            if (tok_item.last)
            begin
                es_next                  = '0;
                en_next                  = '0;
                de_next                  = '0;
                out_valid_next           = 1'b1;
                out_next.language        = lang;
                out_next.spanish_hits    = es_ext[HIT_W-1:0];
                out_next.english_hits    = en_ext[HIT_W-1:0];
                out_next.german_hits     = de_ext[HIT_W-1:0];
            end
            else
            begin
                es_next = es_bump;
                en_next = en_bump;
                de_next = de_bump;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            es_reg        <= '0;
            en_reg        <= '0;
            de_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            es_reg        <= es_next;
            en_reg        <= en_next;
            de_reg        <= de_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

endmodule

/* src/stopword_language_detector_core.sv */
// Top level of the stopword language detector: tokenizer, token queue, scoring stage.
//
//   channel   direction  handshake                    payload
//   byte      in         byte_valid / byte_stall      byte_item   (byte_item_t)
//   result    out        result_valid / result_stall  result_item (result_item_t)
//
// One text byte is taken per cycle while byte_stall is low; one result follows the last byte of a text.
// The last byte's token goes through the token queue, and its result through the output register.
// byte_stall rises only while the token queue is full; the scorer waits on a
// stalled result only when it reaches the next last-byte token.
// Reset clears token length, counters, queue pointers and the result valid.
`include "stopword_language_detector_core_defines.svh"

module stopword_language_detector_core
    import sldet_pkg::*;
#(
    parameter int SCORE_WIDTH = SCORE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    logic   push_valid, push_ready;
    token_t push_item;
    logic   pop_valid, pop_ready;
    token_t pop_item;

    // Split bytes into tokens
    sldet_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .tok_valid  (push_valid),
        .tok_ready  (push_ready),
        .tok_item   (push_item)
    );

    // Decouple tokenizer and scorer
    sldet_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Score tokens and report
    sldet_back #(
        .SCORE_WIDTH (SCORE_WIDTH)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (pop_valid),
        .tok_ready    (pop_ready),
        .tok_item     (pop_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    // Checks
    `SLDET_ASSERT(a_final_pushes, clk, rst_n, (byte_valid && !byte_stall && byte_item.final_byte) |-> push_valid, "last byte accepted without a token push")
    `SLDET_ASSERT(a_last_gives_result, clk, rst_n, (pop_valid && pop_ready && pop_item.last) |=> result_valid, "last token scored without a result")
    `SLDET_NEVER(a_no_overwrite, clk, rst_n, pop_valid && pop_ready && pop_item.last && result_valid && result_stall, "stalled result overwritten")

endmodule
